// ===== hw/rtl/pdcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdcr_pkg
// Shared types, operation codes and unit widths for the distance-constraint
// relaxation block.
// ----------------------------------------------------------------------------
package pdcr_pkg;

  localparam int MAX_POINTS_DEF = 16;

  // Operation codes carried on the input tuser field.
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_CAPTURE = 2'd1;
  localparam logic [1:0] OP_RELAX   = 2'd2;

  // Configuration register indexes.
  localparam logic [0:0] REG_POINT_COUNT = 1'd0;
  localparam logic [0:0] REG_RIGIDITY    = 1'd1;

  localparam int UNIT_BITS = 30;
  localparam int WEIGHT_FRAC = 16;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Square root unit: 64-bit radicand, 32-bit root.
  localparam int SQ_W   = 64;
  localparam int ROOT_W = SQ_W / 2;

  // Divider: dividend, divisor and quotient widths.
  localparam int DIV_DW = 61;
  localparam int DIV_VW = 32;
  localparam int DIV_QW = 31;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    logic [31:0] rest;
    logic [16:0] wf;
    logic [16:0] ws;
  } pair_t;

endpackage

// ===== hw/rtl/pdcr_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdcr_isqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pdcr_isqrt
  import pdcr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CW = $clog2(ROOT_W);

  logic [SQ_W-1:0]   v_r, v_nxt;
  logic [ROOT_W+1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [ROOT_W+3:0] rem_sh;
  logic [ROOT_W+3:0] trial;

  always_comb begin
    v_nxt    = v_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, v_r[SQ_W-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    if (start) begin
      v_nxt    = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      v_nxt = {v_r[SQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = (ROOT_W+2)'(rem_sh - trial);
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[ROOT_W+1:0];
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = CW'(cnt_r + 1'b1);
      if (cnt_r == CW'(ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== hw/rtl/pdcr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdcr_div
// Restoring unsigned divider, one quotient bit per cycle. The upper part of
// the dividend must be below the divisor.
// ----------------------------------------------------------------------------
module pdcr_div
  import pdcr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_DW-1:0] dividend,
  input  logic [DIV_VW-1:0] divisor,
  output logic              done,
  output logic [DIV_QW-1:0] quot
);

  localparam int CW = $clog2(DIV_QW);
  localparam int HW = DIV_DW - DIV_QW;

  logic [DIV_VW-1:0] rem_r, rem_nxt;
  logic [DIV_VW-1:0] dvs_r, dvs_nxt;
  logic [DIV_QW-1:0] q_r, q_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_VW:0]   trial;
  logic              ge;

  always_comb begin
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[DIV_QW-1]};
    ge       = (trial >= {1'b0, dvs_r});
    if (start) begin
      rem_nxt  = {{(DIV_VW-HW){1'b0}}, dividend[DIV_DW-1:DIV_QW]};
      q_nxt    = dividend[DIV_QW-1:0];
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? DIV_VW'(trial - {1'b0, dvs_r}) : trial[DIV_VW-1:0];
      q_nxt   = {q_r[DIV_QW-2:0], ge};
      cnt_nxt = CW'(cnt_r + 1'b1);
      if (cnt_r == CW'(DIV_QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== hw/rtl/pairwise_distance_constraint_relax.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_distance_constraint_relax
// Soft-body distance-constraint solver: point store, rest-shape capture and
// one Gauss-Seidel relaxation sweep over all point pairs.
// ----------------------------------------------------------------------------
// Usage: each input item carries an operation in in_tuser. A load writes one
// point's location, velocity and mass. A capture walks all pairs i<j of the
// points in use and stores each pair's rest distance and two stiffness-scaled
// mass weights. A relax pass walks the pairs in the same order, then emits
// one result item per point with its corrected velocity, out_tlast on the
// final point. Per pair the time is set by the bit-serial square root and
// the shared bit-serial divider (up to two quotients for a capture, three
// for a relax). One item is worked on at a time: in_tready is high only
// while the block is idle. Results wait in an output register while
// out_tready is low; the pass simply holds. Reset clears the control state
// and sets the point count to 16 and the rigidity to 45875; the point and
// pair memories are not cleared and must be written first.
// ----------------------------------------------------------------------------
module pairwise_distance_constraint_relax
  import pdcr_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: point_index[3:0], loc_x, loc_y, loc_z, vel_x, vel_y, vel_z
  // (32 bits each), mass[211:196], zero fill to 216 bits.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [215:0] in_tdata,
  // in_tuser: op[1:0].
  input  logic [1:0]   in_tuser,
  // out_tdata: out_index[3:0], out_vel_x, out_vel_y, out_vel_z (32 bits each).
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [16:0]  cfg_wdata
);

  localparam int PAIRS = MAX_POINTS * (MAX_POINTS - 1) / 2;
  localparam int PW    = $clog2(MAX_POINTS);
  localparam int SW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam logic signed [52:0] FIX_LIM = 53'sd4294967296;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_I, ST_RD_J, ST_DIFF, ST_SCALE, ST_SQ, ST_ROOT_GO, ST_ROOT_WAIT,
    ST_WMUL, ST_WDIV_GO, ST_WDIV_WAIT, ST_WR_PAIR, ST_UDIV_GO, ST_UDIV_WAIT,
    ST_FMUL, ST_CMUL, ST_WR_I, ST_WR_J, ST_NEXT, ST_EM_RD, ST_EM_LD, ST_EM_WAIT
  } state_t;

  function automatic logic signed [34:0] sx35(input logic [31:0] v);
    sx35 = $signed({{3{v[31]}}, v});
  endfunction

  function automatic logic [31:0] sat32(input logic signed [34:0] x);
    if (x > 35'sd2147483647)       sat32 = 32'h7fff_ffff;
    else if (x < -35'sd2147483648) sat32 = 32'h8000_0000;
    else                           sat32 = x[31:0];
  endfunction

  // Memories.
  vec3_t       loc_mem  [MAX_POINTS];
  vec3_t       vel_mem  [MAX_POINTS];
  logic [15:0] mass_mem [MAX_POINTS];
  pair_t       pair_mem [PAIRS];
  vec3_t       loc_rd_r, vel_rd_r;
  logic [15:0] mass_rd_r;
  pair_t       pair_rd_r;

  // Control and datapath registers.
  state_t state_r, state_nxt;
  logic          relax_r, relax_nxt;
  logic [CW-1:0] n_r, n_nxt, i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [1:0]    cnt_r, cnt_nxt, cc_r, cc_nxt;
  logic [4:0]    pc_r;
  logic [16:0]   rig_r;
  vec3_t         loc_i_r, loc_i_nxt, vel_i_r, vel_i_nxt, vel_j_r, vel_j_nxt;
  logic [15:0]   mass_i_r, mass_i_nxt, mass_j_r, mass_j_nxt;
  pair_t         pair_r, pair_nxt;
  logic [2:0][34:0] d_r, d_nxt;
  logic [2:0][30:0] dsm_r, dsm_nxt;
  logic [2:0]    neg_r, neg_nxt;
  logic [1:0]    ksh_r, ksh_nxt;
  logic [63:0]   sum_r, sum_nxt;
  logic [31:0]   root_r, root_nxt;
  logic signed [68:0] prod_r, prod_nxt;
  logic signed [36:0] err_r, err_nxt;
  logic [2:0][31:0] u_r, u_nxt;
  logic signed [33:0] fix1_r, fix1_nxt, fix2_r, fix2_nxt;
  logic          out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [3:0]    out_index_r, out_index_nxt;
  vec3_t         out_vel_r, out_vel_nxt;

  // Combinational controls.
  logic              in_acc;
  logic [CW-1:0]     n_eff;
  logic [16:0]       r_eff;
  logic [16:0]       msum;
  logic [PW-1:0]     pt_raddr;
  logic              ld_we, vel_we;
  logic [PW-1:0]     vel_waddr;
  vec3_t             vel_wdata, ld_loc, ld_vel;
  logic              pair_we;
  logic signed [36:0] mul_a;
  logic signed [31:0] mul_b;
  logic              sq_start, sq_done, dv_start, dv_done;
  logic [SQ_W-1:0]   sq_in;
  logic [ROOT_W-1:0] sq_root;
  logic [DIV_DW-1:0] dv_dividend;
  logic [DIV_VW-1:0] dv_divisor;
  logic [DIV_QW-1:0] dv_quot;
  logic [34:0]       len;
  logic [2:0][33:0]  mag;
  logic [33:0]       mmax;
  logic [1:0]        ksel;
  logic signed [34:0] pi, pj;
  logic signed [52:0] fsh;
  logic signed [33:0] fix_c, corr;
  logic [CW-1:0]     j_inc, i_inc, i_two;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign r_eff     = (rig_r > ONE_Q16) ? ONE_Q16 : rig_r;
  assign msum      = 17'(mass_i_r) + 17'(mass_j_r);
  assign len       = 35'(root_r) << ksh_r;
  assign corr      = prod_r[63:30];
  assign fsh       = prod_r[68:16];
  assign j_inc     = CW'(j_r + 1'b1);
  assign i_inc     = CW'(i_r + 1'b1);
  assign i_two     = CW'(i_r + 2'd2);

  always_comb begin
    if (pc_r < 5'd2)                n_eff = CW'(2);
    else if (32'(pc_r) > MAX_POINTS) n_eff = CW'(MAX_POINTS);
    else                            n_eff = CW'(pc_r);
  end

  always_comb begin
    if (fsh > FIX_LIM)       fix_c = 34'sh1_0000_0000;
    else if (fsh < -FIX_LIM) fix_c = -34'sh1_0000_0000;
    else                     fix_c = fsh[33:0];
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ld_loc[c] = in_tdata[4 + 32*c +: 32];
      ld_vel[c] = in_tdata[100 + 32*c +: 32];
      mag[c]    = d_r[c][34] ? 34'(-$signed(d_r[c])) : d_r[c][33:0];
    end
    mmax = mag[0];
    if (mag[1] > mmax) mmax = mag[1];
    if (mag[2] > mmax) mmax = mag[2];
    if (mmax[33])      ksel = 2'd3;
    else if (mmax[32]) ksel = 2'd2;
    else if (mmax[31]) ksel = 2'd1;
    else               ksel = 2'd0;
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQ: begin
        if (cnt_r != 2'd3) begin
          mul_a = $signed({6'b0, dsm_r[cnt_r]});
          mul_b = $signed({1'b0, dsm_r[cnt_r]});
        end
      end
      ST_WMUL: begin
        mul_a = $signed({21'b0, (cnt_r == 2'd0) ? mass_j_r : mass_i_r});
        mul_b = $signed({15'b0, r_eff});
      end
      ST_FMUL: begin
        mul_a = err_r;
        mul_b = $signed({15'b0, (cnt_r == 2'd0) ? pair_r.wf : pair_r.ws});
      end
      ST_CMUL: begin
        mul_a = (cnt_r == 2'd0) ? 37'(fix1_r) : 37'(fix2_r);
        mul_b = $signed(u_r[cc_r]);
      end
      default: ;
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    relax_nxt = relax_r;
    n_nxt = n_r; i_nxt = i_r; j_nxt = j_r; k_nxt = k_r; s_nxt = s_r;
    cnt_nxt = cnt_r; cc_nxt = cc_r;
    loc_i_nxt = loc_i_r; vel_i_nxt = vel_i_r; vel_j_nxt = vel_j_r;
    mass_i_nxt = mass_i_r; mass_j_nxt = mass_j_r; pair_nxt = pair_r;
    d_nxt = d_r; dsm_nxt = dsm_r; neg_nxt = neg_r; ksh_nxt = ksh_r;
    sum_nxt = sum_r; root_nxt = root_r; err_nxt = err_r; u_nxt = u_r;
    fix1_nxt = fix1_r; fix2_nxt = fix2_r;
    out_valid_nxt = out_valid_r; out_last_nxt = out_last_r;
    out_index_nxt = out_index_r; out_vel_nxt = out_vel_r;
    pt_raddr = i_r[PW-1:0];
    ld_we = 1'b0; vel_we = 1'b0; vel_waddr = PW'(in_tdata[3:0]); vel_wdata = ld_vel;
    pair_we = 1'b0;
    sq_start = 1'b0; sq_in = sum_r;
    dv_start = 1'b0; dv_dividend = '0; dv_divisor = root_r;
    pi = '0; pj = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          i_nxt = '0; j_nxt = CW'(1); s_nxt = '0; n_nxt = n_eff;
          case (in_tuser)
            OP_LOAD: begin
              if (32'(in_tdata[3:0]) < MAX_POINTS) begin
                ld_we  = 1'b1;
                vel_we = 1'b1;
              end
            end
            OP_CAPTURE: begin
              relax_nxt = 1'b0;
              state_nxt = ST_RD_I;
            end
            OP_RELAX: begin
              relax_nxt = 1'b1;
              state_nxt = ST_RD_I;
            end
            default: ;
          endcase
        end
      end
      ST_RD_I: state_nxt = ST_RD_J;
      ST_RD_J: begin
        pt_raddr   = j_r[PW-1:0];
        loc_i_nxt  = loc_rd_r;
        vel_i_nxt  = vel_rd_r;
        mass_i_nxt = mass_rd_r;
        pair_nxt   = pair_rd_r;
        state_nxt  = ST_DIFF;
      end
      ST_DIFF: begin
        vel_j_nxt  = vel_rd_r;
        mass_j_nxt = mass_rd_r;
        for (int c = 0; c < 3; c++) begin
          pi = sx35(loc_i_r[c]) + (relax_r ? sx35(vel_i_r[c]) : 35'sd0);
          pj = sx35(loc_rd_r[c]) + (relax_r ? sx35(vel_rd_r[c]) : 35'sd0);
          d_nxt[c] = 35'(pi - pj);
        end
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        for (int c = 0; c < 3; c++) begin
          dsm_nxt[c] = 31'(mag[c] >> ksel);
          neg_nxt[c] = d_r[c][34];
        end
        ksh_nxt   = ksel;
        sum_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        if (cnt_r != 2'd0) sum_nxt = sum_r + prod_r[63:0];
        if (cnt_r == 2'd3) state_nxt = ST_ROOT_GO;
        cnt_nxt = 2'(cnt_r + 1'b1);
      end
      ST_ROOT_GO: begin
        sq_start  = 1'b1;
        state_nxt = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (sq_done) begin
          root_nxt = sq_root;
          cnt_nxt  = '0;
          if (relax_r) begin
            state_nxt = (sq_root == '0) ? ST_NEXT : ST_UDIV_GO;
          end else begin
            // Rest length is the scaled root, saturated to 32 bits.
            if ((35'(sq_root) << ksh_r) > 35'h0_FFFF_FFFF) pair_nxt.rest = '1;
            else pair_nxt.rest = 32'(35'(sq_root) << ksh_r);
            if (msum == '0) begin
              pair_nxt.wf = '0;
              pair_nxt.ws = '0;
              state_nxt   = ST_WR_PAIR;
            end else begin
              state_nxt = ST_WMUL;
            end
          end
        end
      end
      ST_WMUL: state_nxt = ST_WDIV_GO;
      ST_WDIV_GO: begin
        dv_start    = 1'b1;
        dv_dividend = DIV_DW'(prod_r[31:0]);
        dv_divisor  = DIV_VW'(msum);
        state_nxt   = ST_WDIV_WAIT;
      end
      ST_WDIV_WAIT: begin
        if (dv_done) begin
          if (cnt_r == 2'd0) begin
            pair_nxt.wf = 17'(dv_quot);
            cnt_nxt     = 2'd1;
            state_nxt   = ST_WMUL;
          end else begin
            pair_nxt.ws = 17'(dv_quot);
            state_nxt   = ST_WR_PAIR;
          end
        end
      end
      ST_WR_PAIR: begin
        pair_we   = 1'b1;
        state_nxt = ST_NEXT;
      end
      ST_UDIV_GO: begin
        dv_start    = 1'b1;
        dv_dividend = {dsm_r[cnt_r], {UNIT_BITS{1'b0}}};
        err_nxt     = $signed({5'b0, pair_r.rest}) - $signed({2'b0, len});
        state_nxt   = ST_UDIV_WAIT;
      end
      ST_UDIV_WAIT: begin
        if (dv_done) begin
          u_nxt[cnt_r] = neg_r[cnt_r] ? 32'(-{1'b0, dv_quot}) : {1'b0, dv_quot};
          if (cnt_r == 2'd2) begin
            cnt_nxt   = '0;
            state_nxt = ST_FMUL;
          end else begin
            cnt_nxt   = 2'(cnt_r + 1'b1);
            state_nxt = ST_UDIV_GO;
          end
        end
      end
      ST_FMUL: begin
        // Products: err*wf, then err*ws; each is clamped in the next cycle.
        if (cnt_r == 2'd1) fix1_nxt = fix_c;
        if (cnt_r == 2'd2) begin
          fix2_nxt  = fix_c;
          cnt_nxt   = '0;
          cc_nxt    = '0;
          state_nxt = ST_CMUL;
        end else begin
          cnt_nxt = 2'(cnt_r + 1'b1);
        end
      end
      ST_CMUL: begin
        if (cnt_r == 2'd1) begin
          vel_i_nxt[cc_r] = sat32(sx35(vel_i_r[cc_r]) + 35'(corr));
        end
        if (cnt_r == 2'd2) begin
          vel_j_nxt[cc_r] = sat32(sx35(vel_j_r[cc_r]) - 35'(corr));
          cnt_nxt = '0;
          if (cc_r == 2'd2) state_nxt = ST_WR_I;
          else cc_nxt = 2'(cc_r + 1'b1);
        end else begin
          cnt_nxt = 2'(cnt_r + 1'b1);
        end
      end
      ST_WR_I: begin
        vel_we    = 1'b1;
        vel_waddr = i_r[PW-1:0];
        vel_wdata = vel_i_r;
        state_nxt = ST_WR_J;
      end
      ST_WR_J: begin
        vel_we    = 1'b1;
        vel_waddr = j_r[PW-1:0];
        vel_wdata = vel_j_r;
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        s_nxt = SW'(s_r + 1'b1);
        if (j_inc < n_r) begin
          j_nxt     = j_inc;
          state_nxt = ST_RD_I;
        end else if (i_two < n_r) begin
          i_nxt     = i_inc;
          j_nxt     = i_two;
          state_nxt = ST_RD_I;
        end else begin
          k_nxt     = '0;
          state_nxt = relax_r ? ST_EM_RD : ST_IDLE;
        end
      end
      ST_EM_RD: begin
        pt_raddr  = k_r[PW-1:0];
        state_nxt = ST_EM_LD;
      end
      ST_EM_LD: begin
        out_valid_nxt = 1'b1;
        out_index_nxt = 4'(k_r);
        out_vel_nxt   = vel_rd_r;
        out_last_nxt  = (CW'(k_r + 1'b1) == n_r);
        state_nxt     = ST_EM_WAIT;
      end
      ST_EM_WAIT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          k_nxt         = CW'(k_r + 1'b1);
          state_nxt     = out_last_r ? ST_IDLE : ST_EM_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory ports: point stores read at one address, pair store at s.
  always_ff @(posedge clk) begin
    if (ld_we) begin
      loc_mem[PW'(in_tdata[3:0])]  <= ld_loc;
      mass_mem[PW'(in_tdata[3:0])] <= in_tdata[211:196];
    end
    if (vel_we) vel_mem[vel_waddr] <= vel_wdata;
    if (pair_we) pair_mem[s_r] <= pair_r;
    loc_rd_r  <= loc_mem[pt_raddr];
    vel_rd_r  <= vel_mem[pt_raddr];
    mass_rd_r <= mass_mem[pt_raddr];
    pair_rd_r <= pair_mem[s_r];
  end

  always_ff @(posedge clk) begin
    relax_r <= relax_nxt;
    n_r <= n_nxt; i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt; s_r <= s_nxt;
    cnt_r <= cnt_nxt; cc_r <= cc_nxt;
    loc_i_r <= loc_i_nxt; vel_i_r <= vel_i_nxt; vel_j_r <= vel_j_nxt;
    mass_i_r <= mass_i_nxt; mass_j_r <= mass_j_nxt; pair_r <= pair_nxt;
    d_r <= d_nxt; dsm_r <= dsm_nxt; neg_r <= neg_nxt; ksh_r <= ksh_nxt;
    sum_r <= sum_nxt; root_r <= root_nxt; prod_r <= prod_nxt; err_r <= err_nxt;
    u_r <= u_nxt; fix1_r <= fix1_nxt; fix2_r <= fix2_nxt;
    out_index_r <= out_index_nxt; out_vel_r <= out_vel_nxt; out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pc_r        <= 5'd16;
      rig_r       <= 17'd45875;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_POINT_COUNT: pc_r  <= cfg_wdata[4:0];
          REG_RIGIDITY:    rig_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  pdcr_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_in),
    .done     (sq_done),
    .root     (sq_root)
  );

  pdcr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (dv_dividend),
    .divisor  (dv_divisor),
    .done     (dv_done),
    .quot     (dv_quot)
  );

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_vel_r[2], out_vel_r[1], out_vel_r[0], out_index_r};

endmodule

// ===== hw/rtl/pdcr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdcr_checker
// Port-level checks for the distance-constraint relaxation block.
// ----------------------------------------------------------------------------
module pdcr_checker
  import pdcr_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata,
  input logic         out_tlast
);

  // No new item is taken while results of a pass are pending.
  a_no_accept_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input accepted while a result is pending");

  // Loads, captures and unused codes never produce a result right after.
  a_no_result_after_non_relax: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser != OP_RELAX) |=> !out_tvalid)
    else $error("result after a non-relax item");

  // The last result of a pass closes the output channel.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !out_tvalid)
    else $error("result following the last item of a pass");

  // A stalled result holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind pairwise_distance_constraint_relax pdcr_checker u_pdcr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
